// ===== rtl/max_pool_1d_stream_defines.svh =====
// Assertion macros for the max pooling block.
// No dependencies; included by the files that assert.
`ifndef MAX_POOL_1D_STREAM_DEFINES_SVH
`define MAX_POOL_1D_STREAM_DEFINES_SVH
`ifndef SYNTH
`define MP1D_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("mp1d assertion failed");
`define MP1D_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("mp1d assertion failed");
`else
`define MP1D_ASSERT(lbl, clk, rst, prop)
`define MP1D_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== rtl/mp1d_pkg.sv =====
// Shared constants and float compare for the max pooling block.
// No dependencies.
package mp1d_pkg;
   localparam int unsigned DEF_MAX_CHANNELS = 1024;
   localparam int unsigned SAMPLE_W = 32;
   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 16;
   localparam logic [CSR_ADDR_W-1:0] REG_CHANNEL_COUNT = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_ROW_WIDTH     = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_WINDOW_STRIDE = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_ROW_COUNT     = 2'd3;

   typedef logic [SAMPLE_W-1:0] sample_type;

   function automatic logic is_nan(input sample_type a);
      return a[30:0] > 31'h7F800000;
   endfunction

   // IEEE ordered a > b on raw bits; NaN or +-0 pair gives false
   function automatic logic ordered_greater(input sample_type a, input sample_type b);
      sample_type ka;
      sample_type kb;
      ka = a[31] ? ~a : (a | 32'h8000_0000);
      kb = b[31] ? ~b : (b | 32'h8000_0000);
      if (is_nan(a) || is_nan(b)) return 1'b0;
      if ((a[30:0] | b[30:0]) == 31'd0) return 1'b0;
      return ka > kb;
   endfunction
endpackage

// ===== rtl/mp1d_store.sv =====
// Running-maximum store: one write, one registered read, with write bypass.
// Depends on mp1d_pkg.
module mp1d_store #(
   parameter int unsigned DEPTH  = mp1d_pkg::DEF_MAX_CHANNELS,
   parameter int unsigned ADDR_W = 10
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [ADDR_W-1:0]          wr_addr,
   input  mp1d_pkg::sample_type       wr_data,
   input  logic                       rd_en,
   input  logic [ADDR_W-1:0]          rd_addr,
   output mp1d_pkg::sample_type       rd_data
);
   import mp1d_pkg::*;

   sample_type mem [DEPTH];
   sample_type rd_ff;
   sample_type byp_ff;
   logic       byp_sel_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff      <= mem[rd_addr];
         byp_ff     <= wr_data;
         byp_sel_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   // read happens before the same-edge write lands
   assign rd_data = byp_sel_ff ? byp_ff : rd_ff;
endmodule

// ===== rtl/max_pool_1d_stream.sv =====
// Top level of the streaming 1-D max pooling block.
// Depends on mp1d_pkg, mp1d_store and max_pool_1d_stream_defines.svh.
//
// Channel   | Dir | Handshake        | Payload
// req_      | in  | tvalid/tready    | tdata = sample
// rsp_      | out | tvalid/tready    | tdata = pooled, channel, position; tlast, tuser
// csr_      | in  | we (no wait)     | addr, wdata
//
// One sample per cycle sustained. A sample is registered with its counter
// state and a store read; stage 1 then does the compare and the store
// write, and loads the result register, which drives rsp_tvalid.
// Stalls on rsp_tready only back up when a result must wait; a transfer that
// makes no result still passes. Reset is synchronous, clears the counters and
// valid flags and sets each configuration register to one; the store needs no clearing.
module max_pool_1d_stream #(
   parameter int unsigned MAX_CHANNELS = mp1d_pkg::DEF_MAX_CHANNELS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [31:0]                     req_tdata,   // [31:0] sample
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [63:0]                     rsp_tdata,   // [31:0] pooled, [41:32] out_channel,
                                                        // [57:42] out_position, rest zero
   output logic                            rsp_tlast,   // last_of_row
   output logic                            rsp_tuser,   // last_of_tensor
   input  logic                            csr_we,
   input  logic [mp1d_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [mp1d_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import mp1d_pkg::*;
`include "max_pool_1d_stream_defines.svh"

   localparam int unsigned CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int unsigned CNT_W = 17;

   // configuration
   logic [10:0] cc_cfg_ff;
   logic [15:0] rw_cfg_ff, st_cfg_ff, rc_cfg_ff;

   // counter state
   logic [CH_W-1:0] ch_ff, ch_in;
   logic [15:0]     off_ff, off_in;
   logic [15:0]     pos_ff, pos_in;
   logic [15:0]     wstart_ff, wstart_in;
   logic [15:0]     opos_ff, opos_in;
   logic [15:0]     row_ff, row_in;

   // stage 1
   logic            s1_valid_ff;
   logic            s1_use_ff, s1_first_ff, s1_emit_ff, s1_lrow_ff, s1_lten_ff;
   logic [CH_W-1:0] s1_ch_ff;
   logic [15:0]     s1_opos_ff;
   sample_type      s1_x_ff;

   // result register
   logic        rsp_valid_ff;
   sample_type  rsp_pooled_ff;
   logic [9:0]  rsp_ch_ff;
   logic [15:0] rsp_pos_ff;
   logic        rsp_lrow_ff, rsp_lten_ff;

   logic [CNT_W-1:0] cc_eff, rw_eff, st_eff, rc_eff;
   logic [CNT_W:0]   win_end, win_next_end;
   logic             use_w, first_w, done_w, lastch_w, lrow_w, lten_w;
   logic             accept, out_free, s1_go;
   sample_type       cur_max, new_max;

   always_comb begin
      cc_eff = (cc_cfg_ff == 11'd0) ? CNT_W'(1) : CNT_W'(cc_cfg_ff);
      if (cc_eff > CNT_W'(MAX_CHANNELS)) cc_eff = CNT_W'(MAX_CHANNELS);
      rw_eff = (rw_cfg_ff == 16'd0) ? CNT_W'(1) : CNT_W'(rw_cfg_ff);
      st_eff = (st_cfg_ff == 16'd0) ? CNT_W'(1) : CNT_W'(st_cfg_ff);
      rc_eff = (rc_cfg_ff == 16'd0) ? CNT_W'(1) : CNT_W'(rc_cfg_ff);
   end

   // a window counts only if it ends inside the row; it is the row's last
   // complete window if the following one would not fit
   assign win_end      = (CNT_W+1)'(wstart_ff) + (CNT_W+1)'(st_eff);
   assign win_next_end = win_end + (CNT_W+1)'(st_eff);
   assign use_w        = win_end <= (CNT_W+1)'(rw_eff);
   assign first_w      = off_ff == 16'd0;
   assign done_w       = CNT_W'(off_ff) == st_eff - CNT_W'(1);
   assign lastch_w     = CNT_W'(ch_ff) + CNT_W'(1) >= cc_eff;
   assign lrow_w       = lastch_w && done_w && (win_next_end > (CNT_W+1)'(rw_eff));
   assign lten_w       = lrow_w && (CNT_W'(row_ff) == rc_eff - CNT_W'(1));

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_go      = s1_valid_ff && (!s1_emit_ff || out_free);
   assign req_tready = !s1_valid_ff || s1_go;
   assign accept     = req_tvalid && req_tready;

   // counter advance, channel fastest
   always_comb begin
      ch_in     = ch_ff;
      off_in    = off_ff;
      pos_in    = pos_ff;
      wstart_in = wstart_ff;
      opos_in   = opos_ff;
      row_in    = row_ff;
      if (accept) begin
         ch_in = ch_ff + CH_W'(1);
         if (lastch_w) begin
            ch_in  = '0;
            off_in = off_ff + 16'd1;
            pos_in = pos_ff + 16'd1;
            if (done_w) begin
               off_in    = 16'd0;
               wstart_in = pos_ff + 16'd1;
               opos_in   = opos_ff + 16'd1;
            end
            if (CNT_W'(pos_ff) + CNT_W'(1) >= rw_eff) begin
               pos_in    = 16'd0;
               off_in    = 16'd0;
               wstart_in = 16'd0;
               opos_in   = 16'd0;
               row_in    = row_ff + 16'd1;
               if (CNT_W'(row_ff) + CNT_W'(1) >= rc_eff) row_in = 16'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cc_cfg_ff <= 11'd1;
         rw_cfg_ff <= 16'd1;
         st_cfg_ff <= 16'd1;
         rc_cfg_ff <= 16'd1;
         ch_ff     <= '0;
         off_ff    <= '0;
         pos_ff    <= '0;
         wstart_ff <= '0;
         opos_ff   <= '0;
         row_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_CHANNEL_COUNT: cc_cfg_ff <= csr_wdata[10:0];
            REG_ROW_WIDTH:     rw_cfg_ff <= csr_wdata;
            REG_WINDOW_STRIDE: st_cfg_ff <= csr_wdata;
            REG_ROW_COUNT:     rc_cfg_ff <= csr_wdata;
            default: ;
         endcase
         // any write restarts the counters
         ch_ff     <= '0;
         off_ff    <= '0;
         pos_ff    <= '0;
         wstart_ff <= '0;
         opos_ff   <= '0;
         row_ff    <= '0;
      end else begin
         ch_ff     <= ch_in;
         off_ff    <= off_in;
         pos_ff    <= pos_in;
         wstart_ff <= wstart_in;
         opos_ff   <= opos_in;
         row_ff    <= row_in;
      end
   end

   // stage 1 register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_x_ff     <= req_tdata;
         s1_ch_ff    <= ch_ff;
         s1_opos_ff  <= opos_ff;
         s1_use_ff   <= use_w;
         s1_first_ff <= first_w;
         s1_emit_ff  <= use_w && done_w;
         s1_lrow_ff  <= lrow_w;
         s1_lten_ff  <= lten_w;
      end
   end

   mp1d_store #(
      .DEPTH  (MAX_CHANNELS),
      .ADDR_W (CH_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (s1_go && s1_use_ff),
      .wr_addr (s1_ch_ff),
      .wr_data (new_max),
      .rd_en   (accept),
      .rd_addr (ch_ff),
      .rd_data (cur_max)
   );

   // NaN or equal sample keeps the running value
   assign new_max = (s1_first_ff || ordered_greater(s1_x_ff, cur_max)) ? s1_x_ff : cur_max;

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go && s1_emit_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_emit_ff) begin
         rsp_pooled_ff <= new_max;
         rsp_ch_ff     <= 10'(s1_ch_ff);
         rsp_pos_ff    <= s1_opos_ff;
         rsp_lrow_ff   <= s1_lrow_ff;
         rsp_lten_ff   <= s1_lten_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_pos_ff, rsp_ch_ff, rsp_pooled_ff};
   assign rsp_tlast  = rsp_lrow_ff;
   assign rsp_tuser  = rsp_lten_ff;

   `MP1D_ASSERT(a_tensor_end_is_row_end, clock, reset, rsp_valid_ff |-> (!rsp_lten_ff || rsp_lrow_ff))
   `MP1D_ASSERT(a_channel_in_range, clock, reset, CNT_W'(ch_ff) < cc_eff)
   `MP1D_ASSERT(a_result_channel_in_range, clock, reset, rsp_valid_ff |-> (CNT_W'(rsp_ch_ff) < cc_eff))
endmodule

// ===== tb/sv/tb.sv =====
// Self-checking bench for max_pool_1d_stream: directed and random float32 streams.
// Depends on mp1d_pkg and the max_pool_1d_stream RTL; a scoreboard class predicts results.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mp1d_pkg::*;

   typedef struct packed {
      logic [31:0] pooled;
      logic [9:0]  chan;
      logic [15:0] pos;
      logic        row_end;
      logic        tensor_end;
   } pool_result_type;

   // Window-max predictor plus the queue of pooled results still owed.
   class pool_scoreboard;
      logic [31:0]  run_max [1024];
      int unsigned  ch_idx, pos_idx, win_off, row_idx;
      int unsigned  n_chan, width, stride, rows;
      pool_result_type owed [$];
      int           errors;
      int           n_checked;

      function new();
         n_chan = 1; width = 1; stride = 1; rows = 1;
         ch_idx = 0; pos_idx = 0; win_off = 0; row_idx = 0;
         errors = 0; n_checked = 0;
      endfunction

      function void write_reg(logic [CSR_ADDR_W-1:0] idx, logic [15:0] v);
         case (idx)
            REG_CHANNEL_COUNT: n_chan = v[10:0];
            REG_ROW_WIDTH:     width  = v;
            REG_WINDOW_STRIDE: stride = v;
            REG_ROW_COUNT:     rows   = v;
            default: ;
         endcase
         ch_idx = 0; pos_idx = 0; win_off = 0; row_idx = 0;
      endfunction

      // IEEE ordered a > b on raw bits
      function bit fp_gt(logic [31:0] a, logic [31:0] b);
         logic [31:0] ka, kb;
         if (a[30:0] > 31'h7F80_0000 || b[30:0] > 31'h7F80_0000) return 0;
         if ((a[30:0] | b[30:0]) == 31'd0) return 0;
         ka = a[31] ? ~a : (a | 32'h8000_0000);
         kb = b[31] ? ~b : (b | 32'h8000_0000);
         return ka > kb;
      endfunction

      function void note_sample(logic [31:0] x);
         int unsigned cc, rw, st, rc, covered, ch;
         pool_result_type r;
         cc = (n_chan == 0) ? 1 : n_chan;
         if (cc > 1024) cc = 1024;
         rw = (width == 0) ? 1 : width;
         st = (stride == 0) ? 1 : stride;
         rc = (rows == 0) ? 1 : rows;
         covered = (rw / st) * st;
         ch = (ch_idx < 1024) ? ch_idx : 0;
         if (pos_idx < covered) begin
            if (win_off == 0 || fp_gt(x, run_max[ch])) run_max[ch] = x;
            if (win_off == st - 1) begin
               r.pooled     = run_max[ch];
               r.chan       = ch[9:0];
               r.pos        = 16'(pos_idx / st);
               r.row_end    = (ch == cc - 1) && (pos_idx == covered - 1);
               r.tensor_end = r.row_end && (row_idx == rc - 1);
               owed.push_back(r);
            end
         end
         ch_idx = ch + 1;
         if (ch_idx >= cc) begin
            ch_idx = 0;
            win_off++;
            if (win_off >= st) win_off = 0;
            pos_idx++;
            if (pos_idx >= rw) begin
               pos_idx = 0;
               win_off = 0;
               row_idx++;
               if (row_idx >= rc) row_idx = 0;
            end
         end
      endfunction

      function void check_result(pool_result_type got);
         pool_result_type e;
         n_checked++;
         if (owed.size() == 0) begin
            $display("%0t: unexpected result %h", $realtime, got);
            errors++;
            return;
         end
         e = owed.pop_front();
         if (got.pooled !== e.pooled) begin
            $display("%0t: pooled exp %h got %h", $realtime, e.pooled, got.pooled);
            errors++;
         end
         if (got.chan !== e.chan) begin
            $display("%0t: channel exp %0d got %0d", $realtime, e.chan, got.chan);
            errors++;
         end
         if (got.pos !== e.pos) begin
            $display("%0t: position exp %0d got %0d", $realtime, e.pos, got.pos);
            errors++;
         end
         if (got.row_end !== e.row_end) begin
            $display("%0t: row end exp %b got %b", $realtime, e.row_end, got.row_end);
            errors++;
         end
         if (got.tensor_end !== e.tensor_end) begin
            $display("%0t: tensor end exp %b got %b", $realtime, e.tensor_end,
                     got.tensor_end);
            errors++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [31:0]           req_tdata;   // [31:0] sample
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [63:0]           rsp_tdata;   // [31:0] pooled, [41:32] channel, [57:42] position
   logic                  rsp_tlast;   // last_of_row
   logic                  rsp_tuser;   // last_of_tensor
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   pool_scoreboard pool_sb;
   int          n_sent;
   int          idle_cycles;
   int          squeeze_req;   // count of long receiver hold-offs asked for
   logic [31:0] prev_sample;

   max_pool_1d_stream DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // result monitor: sample at the rising edge, before the block updates
   always @(posedge clock) begin
      pool_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.pooled     = rsp_tdata[31:0];
         got.chan       = rsp_tdata[41:32];
         got.pos        = rsp_tdata[57:42];
         got.row_end    = rsp_tlast;
         got.tensor_end = rsp_tuser;
         pool_sb.check_result(got);
      end
   end

   // receiver: own stall pattern, plus one long hold-off on request
   initial begin
      int hold;
      int mode;
      int squeeze_seen;
      hold = 0;
      squeeze_seen = 0;
      rsp_tready = 0;
      forever begin
         @(negedge clock);
         if (squeeze_req != squeeze_seen) begin
            squeeze_seen = squeeze_req;
            hold = 300;
         end
         if (hold > 0) begin
            hold--;
            rsp_tready = 0;
         end else begin
            mode = int'(($time / 2000) % 3);   // phases: free flow, light, heavy stall
            case (mode)
               0: rsp_tready = 1;
               1: rsp_tready = ($urandom_range(0, 3) != 0);
               default: rsp_tready = ($urandom_range(0, 2) == 0);
            endcase
         end
      end
   end

   // watchdog: cycles with no transfer on either channel
   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles > 5000) begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("max_pool_1d_stream: mismatch");
            $finish;
         end
      end
   end

   // one sample transfer; leaves the caller just after the accepting edge
   task automatic push_sample(logic [31:0] s);
      @(negedge clock);
      req_tvalid = 1;
      req_tdata  = s;
      forever begin
         @(posedge clock);
         if (req_tready) break;
      end
      pool_sb.note_sample(s);
      prev_sample = s;
      n_sent++;
   endtask

   task automatic sender_gap(int n);
      if (n > 0) begin
         @(negedge clock);
         req_tvalid = 0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // block idle: nothing owed, then a margin for stage 1 and the result register to empty
   task automatic wait_drained();
      sender_gap(1);
      while (pool_sb.owed.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_ADDR_W-1:0] idx, logic [15:0] v);
      @(negedge clock);
      csr_we    = 1;
      csr_addr  = idx;
      csr_wdata = v;
      @(negedge clock);
      csr_we = 0;
      pool_sb.write_reg(idx, v);
   endtask

   task automatic set_shape(logic [15:0] cc, logic [15:0] rw, logic [15:0] st,
                            logic [15:0] rc);
      wait_drained();
      write_csr(REG_CHANNEL_COUNT, cc);
      write_csr(REG_ROW_WIDTH, rw);
      write_csr(REG_WINDOW_STRIDE, st);
      write_csr(REG_ROW_COUNT, rc);
   endtask

   // zeros of both signs, NaNs, infinities, repeats, moderate values of both signs and random bits
   function automatic logic [31:0] pick_sample();
      case ($urandom_range(0, 11))
         0: return 32'h0000_0000;
         1: return 32'h8000_0000;
         2: return 32'h7FC0_0000;
         3: return 32'hFF80_0001;
         4: return 32'h7F80_0000;
         5: return 32'hFF80_0000;
         6: return prev_sample;
         7: return {1'b0, 8'($urandom_range(120, 135)), 23'($urandom)};
         8: return {1'b1, 8'($urandom_range(120, 135)), 23'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   task automatic burst_samples(int n);
      int left;
      int burst;
      left = n;
      while (left > 0) begin
         burst = $urandom_range(1, 12);
         while (burst > 0 && left > 0) begin
            push_sample(pick_sample());
            burst--;
            left--;
         end
         if ($urandom_range(0, 2) != 0) sender_gap($urandom_range(1, 6));
      end
   endtask

   initial begin
      int cc, rw, st, rc, n;
      pool_sb     = new();
      n_sent      = 0;
      squeeze_req = 0;
      prev_sample = 32'h3F80_0000;
      reset       = 1;
      req_tvalid  = 0;
      req_tdata   = 0;
      csr_we      = 0;
      csr_addr    = REG_CHANNEL_COUNT;
      csr_wdata   = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // reset shape: every sample is its own window
      push_sample(32'h7F80_0000);
      push_sample(32'hFFFF_FFFF);
      // NaN, equal value and opposite zero keep the running maximum
      set_shape(16'd1, 16'd4, 16'd4, 16'd1);
      push_sample(32'h8000_0000);
      push_sample(32'h0000_0000);
      push_sample(32'h7FC0_0000);
      push_sample(32'h8000_0000);
      set_shape(16'd1, 16'd4, 16'd2, 16'd1);
      push_sample(32'h3F80_0000);
      push_sample(32'h3F80_0000);
      push_sample(32'hFF80_0000);
      push_sample(32'h7FFF_FFFF);
      // zero registers act as one
      set_shape(16'd0, 16'd0, 16'd0, 16'd0);
      push_sample(32'h4000_0000);
      push_sample(32'hC000_0000);
      // tail positions, then a stride wider than the row
      set_shape(16'd2, 16'd5, 16'd2, 16'd2);
      burst_samples(10);
      set_shape(16'd1, 16'd3, 16'd4, 16'd1);
      push_sample(32'h1234_5678);
      push_sample(32'h8765_4321);
      push_sample(32'h5555_5555);
      // oversized channel count clamps; extremes of width and stride
      set_shape(16'hFFFF, 16'hFFFF, 16'd1, 16'hFFFF);
      burst_samples(4);
      set_shape(16'd1024, 16'hFFFF, 16'hFFFF, 16'h8000);
      burst_samples(3);

      // random shapes, mostly whole tensors with random content
      while (n_sent < 300) begin
         cc = $urandom_range(1, 4);
         rw = $urandom_range(1, 10);
         st = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 12) : $urandom_range(1, rw);
         rc = $urandom_range(1, 3);
         set_shape(16'(cc), 16'(rw), 16'(st), 16'(rc));
         n = cc * rw * rc * $urandom_range(1, 2);
         if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);   // cut short
         if (n_sent > 150 && n_sent < 190) squeeze_req++;
         burst_samples(n);
      end
      squeeze_req++;
      burst_samples(60);

      sender_gap(1);
      while (pool_sb.owed.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("run covered %0d samples, %0d pooled results checked", n_sent,
               pool_sb.n_checked);
      $display("shapes: directed extremes and special values, then random tensors");
      if (pool_sb.errors == 0) begin
         $display("max_pool_1d_stream: match");
      end else begin
         $display("max_pool_1d_stream: mismatch");
      end
      $finish;
   end
endmodule
